// ----- hdl/pis_pkg.sv -----
// Shared types and constants for the PID controller with integral separation.
// Used by pis_cfg_regs, pid_integral_separation and pis_checker.
package pis_pkg;

    localparam int DATA_W    = 32;
    localparam int IN_W      = 24;
    localparam int ULIM_W    = 31;
    localparam int CFG_IDX_W = 3;
    localparam int GAIN_FRAC = 16;

    // err = d*4096/100 = d*1024/25 = 40*d + floor(24*d/25) on magnitudes
    localparam int         ERR_INT_MUL  = 40;
    localparam int         ERR_FRAC_MUL = 24;
    localparam int         RECIP_SHIFT  = 34;
    localparam logic [29:0] RECIP_25    = 30'd687194768;  // ceil(2^34 / 25)

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_OUT_UPPER   = 3'd3,
        REG_OUT_LOWER   = 3'd4,
        REG_INTEG_ZONE  = 3'd5,
        REG_INTEG_LIMIT = 3'd6
    } t_reg_idx;

    localparam logic [DATA_W-1:0] RST_PROP_GAIN   = 32'd1311;
    localparam logic [DATA_W-1:0] RST_INTEG_GAIN  = 32'd3277;
    localparam logic [DATA_W-1:0] RST_DERIV_GAIN  = 32'd0;
    localparam logic [DATA_W-1:0] RST_OUT_UPPER   = 32'd98304;
    localparam logic [DATA_W-1:0] RST_OUT_LOWER   = 32'hFFFE_8000;  // -98304
    localparam logic [ULIM_W-1:0] RST_INTEG_ZONE  = 31'h7FFF_FFFF;
    localparam logic [ULIM_W-1:0] RST_INTEG_LIMIT = 31'h7FFF_FFFF;

    typedef struct packed {
        logic signed [IN_W-1:0] ref_value;
        logic signed [IN_W-1:0] measured_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] drive;
        logic                     out_clamped;
    } t_out_item;

    typedef struct packed {
        logic [DATA_W-1:0] prop_gain;
        logic [DATA_W-1:0] integ_gain;
        logic [DATA_W-1:0] deriv_gain;
        logic [DATA_W-1:0] out_upper;
        logic [DATA_W-1:0] out_lower;
        logic [ULIM_W-1:0] integ_zone;
        logic [ULIM_W-1:0] integ_limit;
    } t_cfg;

endpackage

// ----- hdl/pis_cfg_regs.sv -----
// Configuration register bank: gains, output limits, integral zone and limit.
// Depends on pis_pkg.
module pis_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pis_pkg::DATA_W-1:0]    i_cfg_data,
    output pis_pkg::t_cfg                 o_cfg
);
    import pis_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= RST_PROP_GAIN;
            r_cfg.integ_gain  <= RST_INTEG_GAIN;
            r_cfg.deriv_gain  <= RST_DERIV_GAIN;
            r_cfg.out_upper   <= RST_OUT_UPPER;
            r_cfg.out_lower   <= RST_OUT_LOWER;
            r_cfg.integ_zone  <= RST_INTEG_ZONE;
            r_cfg.integ_limit <= RST_INTEG_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_data;
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg_data;
                REG_DERIV_GAIN:  r_cfg.deriv_gain  <= i_cfg_data;
                REG_OUT_UPPER:   r_cfg.out_upper   <= i_cfg_data;
                REG_OUT_LOWER:   r_cfg.out_lower   <= i_cfg_data;
                REG_INTEG_ZONE:  r_cfg.integ_zone  <= i_cfg_data[ULIM_W-1:0];
                REG_INTEG_LIMIT: r_cfg.integ_limit <= i_cfg_data[ULIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hdl/pid_integral_separation.sv -----
// PID controller with integral separation and clamped integral, Q20.12 output.
// Throughput one item per cycle while i_out_ready does not stall the output.
// Seven register stages with bubble collapsing; the stall path runs from i_out_ready.
// The integral and last error live in stage 3, updated once per item in order.
// Synchronous active-low reset empties the pipeline, zeroes integral and last
// error, and loads the reset gains and limits.
module pid_integral_separation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  pis_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output pis_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_we,
    input  logic [pis_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pis_pkg::DATA_W-1:0]    i_cfg_data
);
    import pis_pkg::*;

    t_cfg cfg;

    pis_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // stage valids and advance enables
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_out_valid;
    logic en0, en1, en2, en3, en4, en5, en6;

    assign en6 = !r_out_valid || i_out_ready;
    assign en5 = !r_v5 || en6;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign en0 = !r_v0 || en1;

    assign o_in_ready  = en0;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en0) r_v0        <= i_in_valid;
            if (en1) r_v1        <= r_v0;
            if (en2) r_v2        <= r_v1;
            if (en3) r_v3        <= r_v2;
            if (en4) r_v4        <= r_v3;
            if (en5) r_v5        <= r_v4;
            if (en6) r_out_valid <= r_v5;
        end
    end

    // stage 0: input register
    t_in_item r_s0_item;

    always_ff @(posedge i_clk) begin
        if (en0) r_s0_item <= i_in_item;
    end

    // stage 1: error magnitude, |d|*1024/25 by reciprocal multiply
    logic signed [IN_W:0] diff;
    logic [IN_W:0]        diff_abs;
    logic [IN_W-1:0]      mag_in;
    logic [28:0]          frac_num;
    logic [58:0]          frac_prod;
    logic [29:0]          n_mag;
    logic [29:0]          r_s1_mag;
    logic                 r_s1_neg;

    assign diff      = {r_s0_item.ref_value[IN_W-1], r_s0_item.ref_value}
                     - {r_s0_item.measured_value[IN_W-1], r_s0_item.measured_value};
    assign diff_abs  = diff[IN_W] ? (IN_W+1)'(-diff) : diff;
    assign mag_in    = diff_abs[IN_W-1:0];
    assign frac_num  = 29'(mag_in) * 29'(ERR_FRAC_MUL);
    assign frac_prod = 59'(frac_num) * 59'(RECIP_25);
    assign n_mag     = 30'(mag_in) * 30'(ERR_INT_MUL)
                     + 30'(frac_prod[58:RECIP_SHIFT]);

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_mag <= n_mag;
            r_s1_neg <= diff[IN_W];
        end
    end

    // stage 2: signed error and separation test
    logic signed [DATA_W-1:0] r_s2_err;
    logic                     r_s2_in_zone;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_err     <= r_s1_neg ? -{2'b00, r_s1_mag} : {2'b00, r_s1_mag};
            r_s2_in_zone <= {1'b0, r_s1_mag} < cfg.integ_zone;
        end
    end

    // stage 3: integral update and error difference
    logic signed [DATA_W-1:0] r_sum, r_prev_err, n_sum;
    logic signed [DATA_W:0]   sum_add, lim_pos, lim_neg, derr;
    logic signed [DATA_W-1:0] r_s3_err, r_s3_sum;
    logic signed [DATA_W:0]   r_s3_derr;

    assign sum_add = {r_sum[DATA_W-1], r_sum} + {r_s2_err[DATA_W-1], r_s2_err};
    assign lim_pos = {2'b00, cfg.integ_limit};
    assign lim_neg = -lim_pos;
    assign derr    = {r_s2_err[DATA_W-1], r_s2_err} - {r_prev_err[DATA_W-1], r_prev_err};

    always_comb begin
        n_sum = r_sum;
        if (r_s2_in_zone) begin
            if (sum_add > lim_pos) begin
                n_sum = lim_pos[DATA_W-1:0];
            end else if (sum_add < lim_neg) begin
                n_sum = lim_neg[DATA_W-1:0];
            end else begin
                n_sum = sum_add[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_prev_err <= '0;
        end else if (en3 && r_v2) begin
            r_sum      <= n_sum;
            r_prev_err <= r_s2_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_err  <= r_s2_err;
            r_s3_sum  <= n_sum;
            r_s3_derr <= derr;
        end
    end

    // stage 4: the three gain products
    logic signed [63:0] r_s4_p0, r_s4_p1;
    logic signed [64:0] r_s4_p2;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_s4_p0 <= 64'($signed(cfg.prop_gain))  * 64'(r_s3_err);
            r_s4_p1 <= 64'($signed(cfg.integ_gain)) * 64'(r_s3_sum);
            r_s4_p2 <= 65'($signed(cfg.deriv_gain)) * 65'(r_s3_derr);
        end
    end

    // stage 5: exact sum, floored to Q39.12
    logic signed [66:0] prod_sum;
    logic signed [50:0] r_s5_total;

    assign prod_sum = 67'(r_s4_p0) + 67'(r_s4_p1) + 67'(r_s4_p2);

    always_ff @(posedge i_clk) begin
        if (en5) r_s5_total <= prod_sum[66:GAIN_FRAC];
    end

    // stage 6: upper clamp then lower clamp, into the output register
    logic signed [50:0] upper_w, lower_w;
    logic               over_upper, to_lower;
    t_out_item          n_out_item, r_out_item;

    assign upper_w    = 51'($signed(cfg.out_upper));
    assign lower_w    = 51'($signed(cfg.out_lower));
    assign over_upper = r_s5_total > upper_w;
    // after the upper clamp the value is either upper or the total
    assign to_lower   = over_upper ? (upper_w < lower_w) : (r_s5_total < lower_w);

    always_comb begin
        if (to_lower) begin
            n_out_item.drive = cfg.out_lower;
        end else if (over_upper) begin
            n_out_item.drive = cfg.out_upper;
        end else begin
            n_out_item.drive = r_s5_total[DATA_W-1:0];
        end
        n_out_item.out_clamped = over_upper || to_lower;
    end

    always_ff @(posedge i_clk) begin
        if (en6) r_out_item <= n_out_item;
    end

    assign o_out_item = r_out_item;

endmodule

// ----- hdl/pis_checker.sv -----
// Port-level checks for pid_integral_separation, attached by bind.
// Depends on pis_pkg.
module pis_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input pis_pkg::t_out_item            o_out_item
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // with the output side free the whole pipeline moves, so input is taken
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled while output side is free");

    // a waiting result item holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result item changed while stalled");

endmodule

bind pid_integral_separation pis_checker u_pis_checker (.*);
